/* rtl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, codes and bracket lookup functions for the bracket checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

   // default sizes
   localparam int STACK_DEPTH_DEF    = 32;
   localparam int POSITION_WIDTH_DEF = 16;

   // field widths fixed by the item format
   localparam int CHAR_W  = 8;
   localparam int POS_W   = 16;
   localparam int COUNT_W = 16;
   localparam int KIND_W  = 2;

   // opcodes of an input item
   localparam logic OPCODE_CHAR = 1'b0;
   localparam logic OPCODE_END  = 1'b1;

   // bracket characters
   localparam logic [CHAR_W-1:0] CHAR_OPEN_PAREN   = 8'h28;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_PAREN  = 8'h29;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_SQUARE  = 8'h5B;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_SQUARE = 8'h5D;
   localparam logic [CHAR_W-1:0] CHAR_OPEN_CURLY   = 8'h7B;
   localparam logic [CHAR_W-1:0] CHAR_CLOSE_CURLY  = 8'h7D;

   // bracket kinds held on the stack
   localparam logic [KIND_W-1:0] BRK_PAREN  = 2'd0;
   localparam logic [KIND_W-1:0] BRK_SQUARE = 2'd1;
   localparam logic [KIND_W-1:0] BRK_CURLY  = 2'd2;

   typedef enum logic [2:0] {
      KIND_EXTRA     = 3'd0,
      KIND_MISPLACED = 3'd1,
      KIND_MISSING   = 3'd2,
      KIND_OVERFLOW  = 3'd3,
      KIND_SUMMARY   = 3'd4
   } rsp_kind_type;

   typedef enum logic [1:0] {
      STACK_HOLD = 2'd0,
      STACK_PUSH = 2'd1,
      STACK_POP  = 2'd2
   } stack_op_type;

   typedef enum logic {
      ST_RUN   = 1'b0,
      ST_DRAIN = 1'b1
   } ctrl_state_type;

   typedef struct packed {
      logic              opcode;
      logic [CHAR_W-1:0] character;
   } req_type;

   typedef struct packed {
      rsp_kind_type       kind;
      logic [CHAR_W-1:0]  bracket;
      logic [POS_W-1:0]   position;
      logic [CHAR_W-1:0]  expected;
      logic [POS_W-1:0]   opened_at;
      logic [COUNT_W-1:0] error_count;
      logic               final_item;
   } rsp_type;

   // bracket classification: hit flag plus kind
   typedef struct packed {
      logic              hit;
      logic [KIND_W-1:0] kind;
   } brk_class_type;

   function automatic brk_class_type opener_class(input logic [CHAR_W-1:0] c);
      brk_class_type r;
      r.hit  = 1'b1;
      r.kind = BRK_PAREN;
      case (c)
         CHAR_OPEN_PAREN:  r.kind = BRK_PAREN;
         CHAR_OPEN_SQUARE: r.kind = BRK_SQUARE;
         CHAR_OPEN_CURLY:  r.kind = BRK_CURLY;
         default:          r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic brk_class_type closer_class(input logic [CHAR_W-1:0] c);
      brk_class_type r;
      r.hit  = 1'b1;
      r.kind = BRK_PAREN;
      case (c)
         CHAR_CLOSE_PAREN:  r.kind = BRK_PAREN;
         CHAR_CLOSE_SQUARE: r.kind = BRK_SQUARE;
         CHAR_CLOSE_CURLY:  r.kind = BRK_CURLY;
         default:           r.hit  = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] opener_char(input logic [KIND_W-1:0] k);
      logic [CHAR_W-1:0] r;
      case (k)
         BRK_SQUARE: r = CHAR_OPEN_SQUARE;
         BRK_CURLY:  r = CHAR_OPEN_CURLY;
         default:    r = CHAR_OPEN_PAREN;
      endcase
      return r;
   endfunction

   function automatic logic [CHAR_W-1:0] closer_char(input logic [KIND_W-1:0] k);
      logic [CHAR_W-1:0] r;
      case (k)
         BRK_SQUARE: r = CHAR_CLOSE_SQUARE;
         BRK_CURLY:  r = CHAR_CLOSE_CURLY;
         default:    r = CHAR_CLOSE_PAREN;
      endcase
      return r;
   endfunction

endpackage

/* rtl/bbc_cell.sv */
// ----------------------------------------------------------------------------
// bbc_cell
// One stack slot: on push takes the entry above, on pop the entry below.
// ----------------------------------------------------------------------------
module bbc_cell #(
   parameter int POSITION_WIDTH = bbc_pkg::POSITION_WIDTH_DEF
) (
   input  logic                        clock,
   input  bbc_pkg::stack_op_type       op,
   input  logic [bbc_pkg::KIND_W-1:0]  up_kind,
   input  logic [POSITION_WIDTH-1:0]   up_pos,
   input  logic [bbc_pkg::KIND_W-1:0]  down_kind,
   input  logic [POSITION_WIDTH-1:0]   down_pos,
   output logic [bbc_pkg::KIND_W-1:0]  kind,
   output logic [POSITION_WIDTH-1:0]   pos
);

   logic [bbc_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [POSITION_WIDTH-1:0]  pos_ff, pos_in;

   // shift toward the bottom on push, toward the top on pop
   always_comb begin
      kind_in = kind_ff;
      pos_in  = pos_ff;
      case (op)
         bbc_pkg::STACK_PUSH: begin
            kind_in = up_kind;
            pos_in  = up_pos;
         end
         bbc_pkg::STACK_POP: begin
            kind_in = down_kind;
            pos_in  = down_pos;
         end
         default: begin
            kind_in = kind_ff;
            pos_in  = pos_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
   end

   assign kind = kind_ff;
   assign pos  = pos_ff;

endmodule

/* rtl/bbc_stack.sv */
// ----------------------------------------------------------------------------
// bbc_stack
// Row of cells forming a shift stack; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module bbc_stack #(
   parameter int STACK_DEPTH    = bbc_pkg::STACK_DEPTH_DEF,
   parameter int POSITION_WIDTH = bbc_pkg::POSITION_WIDTH_DEF
) (
   input  logic                        clock,
   input  bbc_pkg::stack_op_type       op,
   input  logic [bbc_pkg::KIND_W-1:0]  push_kind,
   input  logic [POSITION_WIDTH-1:0]   push_pos,
   output logic [bbc_pkg::KIND_W-1:0]  top_kind,
   output logic [POSITION_WIDTH-1:0]   top_pos
);

   logic [bbc_pkg::KIND_W-1:0] cell_kind [STACK_DEPTH];
   logic [POSITION_WIDTH-1:0]  cell_pos  [STACK_DEPTH];

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      logic [bbc_pkg::KIND_W-1:0] up_kind, down_kind;
      logic [POSITION_WIDTH-1:0]  up_pos, down_pos;

      // upper neighbor: new entry for the top cell
      if (i == 0) begin : g_top
         assign up_kind = push_kind;
         assign up_pos  = push_pos;
      end else begin : g_mid
         assign up_kind = cell_kind[i-1];
         assign up_pos  = cell_pos[i-1];
      end

      // lower neighbor: bottom cell refills from itself
      if (i == STACK_DEPTH - 1) begin : g_bot
         assign down_kind = cell_kind[i];
         assign down_pos  = cell_pos[i];
      end else begin : g_low
         assign down_kind = cell_kind[i+1];
         assign down_pos  = cell_pos[i+1];
      end

      bbc_cell #(
         .POSITION_WIDTH (POSITION_WIDTH)
      ) u_cell (
         .clock     (clock),
         .op        (op),
         .up_kind   (up_kind),
         .up_pos    (up_pos),
         .down_kind (down_kind),
         .down_pos  (down_pos),
         .kind      (cell_kind[i]),
         .pos       (cell_pos[i])
      );
   end

   assign top_kind = cell_kind[0];
   assign top_pos  = cell_pos[0];

endmodule

/* rtl/bracket_balance_checker.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker
// Checks bracket balance over a byte stream with a shift stack of cells.
// ----------------------------------------------------------------------------
//  channel  | ports                            | moves
//  ---------+----------------------------------+------------------------------
//  request  | req_valid, req_ready, req_payload | one character or end item
//  response | rsp_valid, rsp_ready, rsp_payload | one error or summary item
//
//  Character items are taken at one item per cycle while the output slot frees.
//  An end item starts a drain pass that pops the stack one cell a cycle while
//  the slot frees, reporting each held opener as missing, then the summary.
//  Requests are held off during the drain. A stalled response stays in the
//  output register; new characters are taken while the slot frees that cycle.
//  Reset clears the counters and the stack count; cell contents are left.
// ----------------------------------------------------------------------------
module bracket_balance_checker #(
   parameter int STACK_DEPTH    = bbc_pkg::STACK_DEPTH_DEF,
   parameter int POSITION_WIDTH = bbc_pkg::POSITION_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bbc_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bbc_pkg::rsp_type rsp_payload
);

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   bbc_pkg::ctrl_state_type       state_ff, state_in;
   logic [CNT_W-1:0]              count_ff, count_in;
   logic [POSITION_WIDTH-1:0]     pos_ff, pos_in;
   logic [bbc_pkg::COUNT_W-1:0]   errors_ff, errors_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   bbc_pkg::rsp_type              rsp_ff, rsp_in;
   logic                          load_rsp;

   bbc_pkg::stack_op_type         stack_op;
   logic [bbc_pkg::KIND_W-1:0]    top_kind;
   logic [POSITION_WIDTH-1:0]     top_pos;

   logic                          slot_free;
   logic                          accept;
   logic [POSITION_WIDTH-1:0]     pos_inc;
   logic [bbc_pkg::COUNT_W-1:0]   errors_inc;
   logic [bbc_pkg::POS_W-1:0]     pos_out;
   logic [bbc_pkg::POS_W-1:0]     top_pos_out;
   bbc_pkg::brk_class_type        open_c, close_c;

   bbc_stack #(
      .STACK_DEPTH    (STACK_DEPTH),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_stack (
      .clock     (clock),
      .op        (stack_op),
      .push_kind (open_c.kind),
      .push_pos  (pos_inc),
      .top_kind  (top_kind),
      .top_pos   (top_pos)
   );

   // handshake and saturating counters
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == bbc_pkg::ST_RUN) && slot_free;
   assign accept     = req_valid && req_ready;
   assign pos_inc    = (pos_ff == '1) ? pos_ff : pos_ff + 1'b1;
   assign errors_inc = (errors_ff == '1) ? errors_ff : errors_ff + 1'b1;
   assign open_c     = bbc_pkg::opener_class(req_payload.character);
   assign close_c    = bbc_pkg::closer_class(req_payload.character);

   // positions shown on the response are the low bits, zero extended
   logic [31:0] pos_wide, top_pos_wide;
   assign pos_wide     = 32'(pos_inc);
   assign top_pos_wide = 32'(top_pos);
   assign pos_out      = pos_wide[bbc_pkg::POS_W-1:0];
   assign top_pos_out  = top_pos_wide[bbc_pkg::POS_W-1:0];

   // next state, stack control and response build
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      errors_in = errors_ff;
      stack_op  = bbc_pkg::STACK_HOLD;
      load_rsp  = 1'b0;
      rsp_in    = '0;
      case (state_ff)
         bbc_pkg::ST_RUN: begin
            if (accept && req_payload.opcode == bbc_pkg::OPCODE_CHAR) begin
               pos_in              = pos_inc;
               rsp_in.bracket      = req_payload.character;
               rsp_in.position     = pos_out;
               rsp_in.error_count  = errors_inc;
               if (open_c.hit) begin
                  if (count_ff != CNT_FULL) begin
                     stack_op = bbc_pkg::STACK_PUSH;
                     count_in = count_ff + 1'b1;
                  end else begin
                     errors_in   = errors_inc;
                     load_rsp    = 1'b1;
                     rsp_in.kind = bbc_pkg::KIND_OVERFLOW;
                  end
               end else if (close_c.hit) begin
                  if (count_ff == '0) begin
                     errors_in   = errors_inc;
                     load_rsp    = 1'b1;
                     rsp_in.kind = bbc_pkg::KIND_EXTRA;
                  end else begin
                     stack_op = bbc_pkg::STACK_POP;
                     count_in = count_ff - 1'b1;
                     if (top_kind != close_c.kind) begin
                        errors_in        = errors_inc;
                        load_rsp         = 1'b1;
                        rsp_in.kind      = bbc_pkg::KIND_MISPLACED;
                        rsp_in.expected  = bbc_pkg::closer_char(top_kind);
                        rsp_in.opened_at = top_pos_out;
                     end
                  end
               end
            end else if (accept) begin
               state_in = bbc_pkg::ST_DRAIN;
            end
         end
         bbc_pkg::ST_DRAIN: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               if (count_ff != '0) begin
                  // report the top opener as missing its closer
                  stack_op           = bbc_pkg::STACK_POP;
                  count_in           = count_ff - 1'b1;
                  errors_in          = errors_inc;
                  rsp_in.kind        = bbc_pkg::KIND_MISSING;
                  rsp_in.bracket     = bbc_pkg::opener_char(top_kind);
                  rsp_in.position    = top_pos_out;
                  rsp_in.error_count = errors_inc;
               end else begin
                  // summary, then back to a fresh sequence
                  rsp_in.kind        = bbc_pkg::KIND_SUMMARY;
                  rsp_in.error_count = errors_ff;
                  rsp_in.final_item  = 1'b1;
                  pos_in             = '0;
                  errors_in          = '0;
                  state_in           = bbc_pkg::ST_RUN;
               end
            end
         end
         default: begin
            state_in = bbc_pkg::ST_RUN;
         end
      endcase
   end

   // output register valid
   always_comb begin
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bbc_pkg::ST_RUN;
         count_ff     <= '0;
         pos_ff       <= '0;
         errors_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         errors_ff    <= errors_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

/* verif/bracket_balance_checker_test.sv */
// ----------------------------------------------------------------------------
// bracket_balance_checker_test
// Self-checking bench for the bracket checker. A directed table covers the
// extra, misplaced and missing errors, ignored bytes, empty and drained
// sequences. Random sequences follow, mostly well formed, some broken, some
// deep enough to overflow the stack, plus noise. Each result item is checked
// against a local model of the stack. Sender and receiver idle in phases.
// ----------------------------------------------------------------------------
module bracket_balance_checker_test;

   localparam int STACK_LIMIT = bbc_pkg::STACK_DEPTH_DEF;
   localparam logic [bbc_pkg::POS_W-1:0] POS_TOP = {bbc_pkg::POS_W{1'b1}};
   localparam logic [bbc_pkg::COUNT_W-1:0] COUNT_TOP = {bbc_pkg::COUNT_W{1'b1}};
   localparam logic [bbc_pkg::CHAR_W-1:0] OPENERS [3] = '{bbc_pkg::CHAR_OPEN_PAREN,
                                                          bbc_pkg::CHAR_OPEN_SQUARE,
                                                          bbc_pkg::CHAR_OPEN_CURLY};
   localparam logic [bbc_pkg::CHAR_W-1:0] CLOSERS [3] = '{bbc_pkg::CHAR_CLOSE_PAREN,
                                                          bbc_pkg::CHAR_CLOSE_SQUARE,
                                                          bbc_pkg::CHAR_CLOSE_CURLY};
   localparam int RANDOM_PER_PHASE = 30;

   typedef struct {
      bbc_pkg::req_type item;
      bit               typed;
      bbc_pkg::rsp_type want;
   } stim_row_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   bbc_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   bbc_pkg::rsp_type rsp_payload;

   // model state
   logic [bbc_pkg::KIND_W-1:0]  open_kind [STACK_LIMIT];
   logic [bbc_pkg::POS_W-1:0]   open_pos [STACK_LIMIT];
   int unsigned                 held_count = 0;
   logic [bbc_pkg::POS_W-1:0]   char_pos = '0;
   logic [bbc_pkg::COUNT_W-1:0] error_total = '0;

   bbc_pkg::rsp_type pending_rsps [$];
   bbc_pkg::rsp_type want_rsp;
   stim_row_type     directed_rows [$];
   int               fail_count = 0;
   int               sent_items = 0;
   int               idle_pct = 0;
   int               stall_pct = 0;

   bracket_balance_checker dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always #5 clock = ~clock;

   // receiver stalls at the rate of the current phase
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %h want %h", name, got, want));
      end
   endtask

   function automatic bbc_pkg::rsp_type make_rsp(input bbc_pkg::rsp_kind_type k,
                                                 input logic [7:0] b,
                                                 input logic [15:0] p, input logic [7:0] e,
                                                 input logic [15:0] o, input logic [15:0] n);
      bbc_pkg::rsp_type r;
      r.kind        = k;
      r.bracket     = b;
      r.position    = p;
      r.expected    = e;
      r.opened_at   = o;
      r.error_count = n;
      r.final_item  = (k == bbc_pkg::KIND_SUMMARY);
      return r;
   endfunction

   // one error: bump the saturating count, queue the result
   task automatic log_error(input bbc_pkg::rsp_kind_type k, input logic [7:0] b,
                            input logic [15:0] p, input logic [7:0] e,
                            input logic [15:0] o);
      if (error_total != COUNT_TOP) error_total++;
      pending_rsps.push_back(make_rsp(k, b, p, e, o, error_total));
   endtask

   // bracket matching model: updates the stack, queues the results of one item
   task automatic predict_brackets(input bbc_pkg::req_type r);
      int ok;
      int kc;
      int i;
      ok = -1;
      kc = -1;
      if (r.opcode == bbc_pkg::OPCODE_CHAR) begin
         for (i = 0; i < 3; i++) begin
            if (r.character == OPENERS[i]) ok = i;
            if (r.character == CLOSERS[i]) kc = i;
         end
         if (char_pos != POS_TOP) char_pos++;
         if (ok >= 0) begin
            if (held_count < STACK_LIMIT) begin
               open_kind[held_count] = ok[bbc_pkg::KIND_W-1:0];
               open_pos[held_count]  = char_pos;
               held_count++;
            end else begin
               log_error(bbc_pkg::KIND_OVERFLOW, r.character, char_pos, '0, '0);
            end
         end else if (kc >= 0) begin
            if (held_count == 0) begin
               log_error(bbc_pkg::KIND_EXTRA, r.character, char_pos, '0, '0);
            end else begin
               held_count--;
               if (open_kind[held_count] != kc) begin
                  log_error(bbc_pkg::KIND_MISPLACED, r.character, char_pos,
                            CLOSERS[open_kind[held_count]], open_pos[held_count]);
               end
            end
         end
      end else begin
         // end item: drain top first, then the summary, then clear
         while (held_count > 0) begin
            held_count--;
            log_error(bbc_pkg::KIND_MISSING, OPENERS[open_kind[held_count]],
                      open_pos[held_count], '0, '0);
         end
         pending_rsps.push_back(make_rsp(bbc_pkg::KIND_SUMMARY, '0, '0, '0, '0,
                                         error_total));
         char_pos    = '0;
         error_total = '0;
      end
   endtask

   // present one item and hold it until taken
   task automatic present_item(input bbc_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      sent_items++;
   endtask

   // present one item, then predict its results
   task automatic send_item(input bbc_pkg::req_type r);
      present_item(r);
      predict_brackets(r);
   endtask

   task automatic send_char(input logic [7:0] c);
      bbc_pkg::req_type r;
      r.opcode    = bbc_pkg::OPCODE_CHAR;
      r.character = c;
      send_item(r);
   endtask

   task automatic send_end();
      bbc_pkg::req_type r;
      r.opcode    = bbc_pkg::OPCODE_END;
      r.character = 8'($urandom_range(255));
      send_item(r);
   endtask

   // sender holds off until every expected result has come
   task automatic wait_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_rsps.size() != 0);
   endtask

   function automatic bit is_bracket(input logic [7:0] c);
      int i;
      for (i = 0; i < 3; i++) begin
         if (c == OPENERS[i] || c == CLOSERS[i]) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] filler_byte();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (is_bracket(c));
      return c;
   endfunction

   // nested sequence with filler; broken ones get a stray bracket and may stay open
   task automatic gen_nested(input bit broken);
      logic [bbc_pkg::KIND_W-1:0] kinds [$];
      int steps;
      int spot;
      int k;
      int s;
      steps = $urandom_range(2, 16);
      spot  = broken ? $urandom_range(0, steps - 1) : -1;
      for (s = 0; s < steps; s++) begin
         if (s == spot) begin
            send_char($urandom_range(1) ? OPENERS[$urandom_range(2)]
                                        : CLOSERS[$urandom_range(2)]);
         end else if (kinds.size() != 0 && $urandom_range(1)) begin
            send_char(CLOSERS[kinds.pop_back()]);
         end else if ($urandom_range(3) == 0) begin
            send_char(filler_byte());
         end else begin
            k = $urandom_range(2);
            kinds.push_back(k[bbc_pkg::KIND_W-1:0]);
            send_char(OPENERS[k]);
         end
      end
      if (!broken || $urandom_range(1)) begin
         while (kinds.size() != 0) send_char(CLOSERS[kinds.pop_back()]);
      end
      send_end();
   endtask

   // deep nest around the stack limit, a few closers, then drain
   task automatic gen_deep();
      int n;
      int s;
      n = $urandom_range(STACK_LIMIT - 2, STACK_LIMIT + 4);
      for (s = 0; s < n; s++) send_char(OPENERS[$urandom_range(2)]);
      n = $urandom_range(0, 3);
      for (s = 0; s < n; s++) send_char(CLOSERS[$urandom_range(2)]);
      send_end();
   endtask

   // raw bytes of any value, occasional end items
   task automatic gen_noise();
      int n;
      int s;
      n = $urandom_range(1, 8);
      for (s = 0; s < n; s++) begin
         if ($urandom_range(4) == 0) send_end();
         else send_char(8'($urandom_range(255)));
      end
   endtask

   task automatic random_phase(input int send_idle, input int recv_stall);
      int target;
      int pick;
      idle_pct  = send_idle;
      stall_pct = recv_stall;
      target    = sent_items + RANDOM_PER_PHASE;
      while (sent_items < target) begin
         pick = $urandom_range(99);
         if (pick < 50) gen_nested(1'b0);
         else if (pick < 70) gen_nested(1'b1);
         else if (pick < 82) gen_deep();
         else gen_noise();
      end
      wait_results();
   endtask

   function automatic stim_row_type plain_row(input logic op, input logic [7:0] c);
      stim_row_type row;
      row.item.opcode    = op;
      row.item.character = c;
      row.typed          = 1'b0;
      row.want           = '0;
      return row;
   endfunction

   function automatic stim_row_type typed_row(input logic op, input logic [7:0] c,
                                              input bbc_pkg::rsp_kind_type k,
                                              input logic [7:0] b,
                                              input logic [15:0] p, input logic [7:0] e,
                                              input logic [15:0] o, input logic [15:0] n);
      stim_row_type row;
      row       = plain_row(op, c);
      row.typed = 1'b1;
      row.want  = make_rsp(k, b, p, e, o, n);
      return row;
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            report_mismatch("result item with nothing expected");
         end else begin
            want_rsp = pending_rsps.pop_front();
            check_field("kind", 16'(rsp_payload.kind), 16'(want_rsp.kind));
            check_field("bracket", 16'(rsp_payload.bracket), 16'(want_rsp.bracket));
            check_field("position", rsp_payload.position, want_rsp.position);
            check_field("expected", 16'(rsp_payload.expected), 16'(want_rsp.expected));
            check_field("opened_at", rsp_payload.opened_at, want_rsp.opened_at);
            check_field("error_count", rsp_payload.error_count, want_rsp.error_count);
            check_field("final_item", 16'(rsp_payload.final_item),
                        16'(want_rsp.final_item));
         end
      end
   end

   // watchdog
   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      int row_idx;
      int mark;

      // empty sequence right after reset
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_END, 8'h00, bbc_pkg::KIND_SUMMARY,
                                        8'h00, 16'd0, 8'h00, 16'd0, 16'd0));
      // closers on an empty stack
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_PAREN,
                                        bbc_pkg::KIND_EXTRA, bbc_pkg::CHAR_CLOSE_PAREN,
                                        16'd1, 8'h00, 16'd0, 16'd1));
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_SQUARE,
                                        bbc_pkg::KIND_EXTRA, bbc_pkg::CHAR_CLOSE_SQUARE,
                                        16'd2, 8'h00, 16'd0, 16'd2));
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_CURLY,
                                        bbc_pkg::KIND_EXTRA, bbc_pkg::CHAR_CLOSE_CURLY,
                                        16'd3, 8'h00, 16'd0, 16'd3));
      // kind mismatches
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_PAREN));
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_SQUARE,
                                        bbc_pkg::KIND_MISPLACED, bbc_pkg::CHAR_CLOSE_SQUARE,
                                        16'd5, bbc_pkg::CHAR_CLOSE_PAREN, 16'd4, 16'd4));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_CURLY));
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_PAREN,
                                        bbc_pkg::KIND_MISPLACED, bbc_pkg::CHAR_CLOSE_PAREN,
                                        16'd7, bbc_pkg::CHAR_CLOSE_CURLY, 16'd6, 16'd5));
      // matched pairs and ignored bytes at the extremes
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_SQUARE));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_PAREN));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_PAREN));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_SQUARE));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, 8'h00));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, 8'hFF));
      // openers left for the drain
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_CURLY));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_SQUARE));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_END, 8'h00));
      // balanced pair, end item with all character bits set
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_OPEN_PAREN));
      directed_rows.push_back(plain_row(bbc_pkg::OPCODE_CHAR, bbc_pkg::CHAR_CLOSE_PAREN));
      directed_rows.push_back(typed_row(bbc_pkg::OPCODE_END, 8'hFF, bbc_pkg::KIND_SUMMARY,
                                        8'h00, 16'd0, 8'h00, 16'd0, 16'd0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table, no idling; typed rows replace the predicted results
      for (row_idx = 0; row_idx < directed_rows.size(); row_idx++) begin
         present_item(directed_rows[row_idx].item);
         mark = pending_rsps.size();
         predict_brackets(directed_rows[row_idx].item);
         if (directed_rows[row_idx].typed) begin
            while (pending_rsps.size() > mark) void'(pending_rsps.pop_back());
            pending_rsps.push_back(directed_rows[row_idx].want);
         end
      end
      wait_results();

      // random phases: none, sender idle, receiver stall, both
      random_phase(0, 0);
      random_phase(68, 0);
      random_phase(0, 68);
      random_phase(29, 29);

      repeat (40) @(posedge clock);
      if (fail_count == 0 && pending_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
